// ----- sv/bads_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box average downscaler package
// Shared constants, register indexes and the flag set that travels with each
// block column update from the front end to the back end.
// ----------------------------------------------------------------------------
package bads_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_FACTOR_DEF = 16;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int PIX_W  = 8;
   localparam int ZOOM_W = 5;
   localparam int DIM_W  = 13;
   localparam int ROW_W  = 15;
   localparam int CSR_W  = 2;

   localparam int FIFO_DEPTH = 4;

   typedef enum logic [CSR_W-1:0] {
      CSR_ZOOM   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } bads_csr_type;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic row_end;
      logic frame_end;
   } bads_flags_type;

endpackage
`default_nettype wire

// ----- sv/box_average_image_downscaler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box average image downscaler
// Averages non-overlapping square blocks of a grey raster frame into one
// output pixel each, with row and frame end flags.
// ----------------------------------------------------------------------------
// Throughput: one input pixel per cycle while the four-entry update queue has
// room; each finished block column segment passes through the back end's idle
// and accumulate states, and each block average then through the bit-serial
// divider (one quotient bit a cycle), so the column store port and the divider
// set the sustained rate.
// Reset: position counters cleared, factor 1 and a 4096 by 4096 frame; the
// column store is not cleared, since every entry is written before it is read.
module box_average_image_downscaler_unit #(
   parameter int MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [bads_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [bads_pkg::DIM_W-1:0]   csr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [bads_pkg::PIX_W-1:0]   req_pixel,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [bads_pkg::PIX_W-1:0]        rsp_avg_pixel,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end
);

   localparam int FW_RAW = $clog2(MAX_FACTOR + 1);
   localparam int FW     = (FW_RAW > bads_pkg::ZOOM_W) ? FW_RAW : bads_pkg::ZOOM_W;
   localparam int CW_RAW = $clog2(MAX_WIDTH + 3 * MAX_FACTOR + 1);
   localparam int CW     = (CW_RAW > bads_pkg::DIM_W + 1) ? CW_RAW : bads_pkg::DIM_W + 1;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int SW     = bads_pkg::PIX_W + 2 * $clog2(MAX_FACTOR);
   localparam int DW     = 2 * FW;
   localparam int YW     = bads_pkg::ROW_W;
   localparam int FLW    = $bits(bads_pkg::bads_flags_type);
   localparam int QW     = AW + SW + FLW;
   localparam int W_RST  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

   logic [FW-1:0] f_ff;
   logic [CW-1:0] w_ff;
   logic [YW-1:0] h_ff;
   logic [DW-1:0] fsq_ff;

   logic          csr_write;
   logic          restart;
   logic [FW-1:0] f_raw;
   logic [FW-1:0] f_cl;
   logic [CW-1:0] w_raw;
   logic [CW-1:0] w_cl;
   logic [YW-1:0] h_raw;
   logic [YW-1:0] h_cl;

   logic                     push_valid;
   logic                     push_full;
   logic [AW-1:0]            push_col;
   logic [SW-1:0]            push_sum;
   bads_pkg::bads_flags_type push_flags;
   logic                     pop;
   logic                     pop_empty;
   logic [QW-1:0]            pop_data;
   logic [AW-1:0]            pop_col;
   logic [SW-1:0]            pop_sum;
   bads_pkg::bads_flags_type pop_flags;

   always_comb begin
      csr_ready = 1'b1;
      csr_write = csr_valid & csr_ready;
      f_raw     = FW'(csr_data[bads_pkg::ZOOM_W-1:0]);
      w_raw     = CW'(csr_data);
      h_raw     = YW'(csr_data);
      if (f_raw == '0) begin
         f_cl = FW'(1);
      end else if (f_raw > FW'(MAX_FACTOR)) begin
         f_cl = FW'(MAX_FACTOR);
      end else begin
         f_cl = f_raw;
      end
      if (w_raw == '0) begin
         w_cl = CW'(1);
      end else if (w_raw > CW'(MAX_WIDTH)) begin
         w_cl = CW'(MAX_WIDTH);
      end else begin
         w_cl = w_raw;
      end
      if (h_raw == '0) begin
         h_cl = YW'(1);
      end else if (h_raw > YW'(bads_pkg::HEIGHT_LIMIT)) begin
         h_cl = YW'(bads_pkg::HEIGHT_LIMIT);
      end else begin
         h_cl = h_raw;
      end
      case (bads_pkg::bads_csr_type'(csr_index))
         bads_pkg::CSR_ZOOM:   restart = csr_write;
         bads_pkg::CSR_WIDTH:  restart = csr_write;
         bads_pkg::CSR_HEIGHT: restart = csr_write;
         default:              restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff   <= FW'(1);
         w_ff   <= CW'(W_RST);
         h_ff   <= YW'(bads_pkg::HEIGHT_LIMIT);
         fsq_ff <= DW'(1);
      end else if (csr_write) begin
         case (bads_pkg::bads_csr_type'(csr_index))
            bads_pkg::CSR_ZOOM: begin
               f_ff   <= f_cl;
               fsq_ff <= DW'(f_cl) * DW'(f_cl);
            end
            bads_pkg::CSR_WIDTH: begin
               w_ff <= w_cl;
            end
            bads_pkg::CSR_HEIGHT: begin
               h_ff <= h_cl;
            end
            default: begin
            end
         endcase
      end
   end

   bads_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .f          (f_ff),
      .w          (w_ff),
      .h          (h_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .push_full  (push_full),
      .push_valid (push_valid),
      .push_col   (push_col),
      .push_sum   (push_sum),
      .push_flags (push_flags)
   );

   bads_fifo #(
      .DATA_W (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_col, push_sum, push_flags}),
      .full      (push_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (pop_empty)
   );

   assign {pop_col, pop_sum, pop_flags} = pop_data;

   bads_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .fsq           (fsq_ff),
      .pop_empty     (pop_empty),
      .pop           (pop),
      .pop_col       (pop_col),
      .pop_sum       (pop_sum),
      .pop_flags     (pop_flags),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_avg_pixel (rsp_avg_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

// ----- sv/bads_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box average downscaler front end
// Tracks the raster position, drops pixels outside whole blocks, forms the
// horizontal block sums and queues one update per finished block segment.
// ----------------------------------------------------------------------------
module bads_front #(
   parameter int MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                restart,
   input  wire logic [FW-1:0]                       f,
   input  wire logic [CW-1:0]                       w,
   input  wire logic [bads_pkg::ROW_W-1:0]          h,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bads_pkg::PIX_W-1:0]          req_pixel,
   input  wire logic                                push_full,
   output logic                                     push_valid,
   output logic [AW-1:0]                            push_col,
   output logic [SW-1:0]                            push_sum,
   output bads_pkg::bads_flags_type                 push_flags
);

   localparam int FW_RAW = $clog2(MAX_FACTOR + 1);
   localparam int FW     = (FW_RAW > bads_pkg::ZOOM_W) ? FW_RAW : bads_pkg::ZOOM_W;
   localparam int CW_RAW = $clog2(MAX_WIDTH + 3 * MAX_FACTOR + 1);
   localparam int CW     = (CW_RAW > bads_pkg::DIM_W + 1) ? CW_RAW : bads_pkg::DIM_W + 1;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int SW     = bads_pkg::PIX_W + 2 * $clog2(MAX_FACTOR);
   localparam int YW     = bads_pkg::ROW_W;

   logic [CW-1:0] in_col_ff, in_col_in;
   logic [CW-1:0] blk_x_ff, blk_x_in;
   logic [AW-1:0] col_idx_ff, col_idx_in;
   logic [FW-1:0] sub_col_ff, sub_col_in;
   logic [YW-1:0] in_row_ff, in_row_in;
   logic [YW-1:0] blk_y_ff, blk_y_in;
   logic [FW-1:0] sub_row_ff, sub_row_in;
   logic [SW-1:0] bsum_ff, bsum_in;

   logic          accept;
   logic          x_ok;
   logic          y_ok;
   logic          col_wrap;
   logic          row_wrap;
   logic          line_end;
   logic          frame_wrap;
   logic          row_last;
   logic [SW-1:0] hsum;

   always_comb begin
      accept     = req_valid & ~push_full;
      x_ok       = (blk_x_ff + CW'(f)) <= w;
      y_ok       = (blk_y_ff + YW'(f)) <= h;
      col_wrap   = ({1'b0, sub_col_ff} + (FW + 1)'(1)) >= {1'b0, f};
      row_wrap   = ({1'b0, sub_row_ff} + (FW + 1)'(1)) >= {1'b0, f};
      line_end   = (in_col_ff + CW'(1)) >= w;
      frame_wrap = (in_row_ff + YW'(1)) >= h;
      row_last   = (blk_x_ff + CW'(f) + CW'(f)) > w;
      hsum       = (sub_col_ff == '0) ? SW'(req_pixel) : bsum_ff + SW'(req_pixel);

      req_stall             = push_full;
      push_valid            = accept & x_ok & y_ok & col_wrap;
      push_col              = col_idx_ff;
      push_sum              = hsum;
      push_flags.first_row  = (sub_row_ff == '0);
      push_flags.last_row   = row_wrap;
      push_flags.row_end    = row_last;
      push_flags.frame_end  = row_last & ((blk_y_ff + YW'(f) + YW'(f)) > h);

      in_col_in  = in_col_ff;
      blk_x_in   = blk_x_ff;
      col_idx_in = col_idx_ff;
      sub_col_in = sub_col_ff;
      in_row_in  = in_row_ff;
      blk_y_in   = blk_y_ff;
      sub_row_in = sub_row_ff;
      bsum_in    = bsum_ff;

      if (restart) begin
         in_col_in  = '0;
         blk_x_in   = '0;
         col_idx_in = '0;
         sub_col_in = '0;
         in_row_in  = '0;
         blk_y_in   = '0;
         sub_row_in = '0;
         bsum_in    = '0;
      end else if (accept) begin
         if (x_ok && y_ok) begin
            bsum_in = hsum;
         end
         if (line_end) begin
            in_col_in  = '0;
            blk_x_in   = '0;
            col_idx_in = '0;
            sub_col_in = '0;
            if (frame_wrap) begin
               in_row_in  = '0;
               blk_y_in   = '0;
               sub_row_in = '0;
            end else begin
               in_row_in = in_row_ff + YW'(1);
               if (row_wrap) begin
                  sub_row_in = '0;
                  blk_y_in   = blk_y_ff + YW'(f);
               end else begin
                  sub_row_in = sub_row_ff + FW'(1);
               end
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
            if (col_wrap) begin
               sub_col_in = '0;
               blk_x_in   = blk_x_ff + CW'(f);
               col_idx_in = col_idx_ff + AW'(1);
            end else begin
               sub_col_in = sub_col_ff + FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         blk_x_ff   <= '0;
         col_idx_ff <= '0;
         sub_col_ff <= '0;
         in_row_ff  <= '0;
         blk_y_ff   <= '0;
         sub_row_ff <= '0;
         bsum_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         blk_x_ff   <= blk_x_in;
         col_idx_ff <= col_idx_in;
         sub_col_ff <= sub_col_in;
         in_row_ff  <= in_row_in;
         blk_y_ff   <= blk_y_in;
         sub_row_ff <= sub_row_in;
         bsum_ff    <= bsum_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/bads_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box average downscaler update queue
// Short show-ahead queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bads_fifo #(
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty
);

   localparam int DEPTH = bads_pkg::FIFO_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] data_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == NW'(DEPTH));
      empty     = (count_ff == '0);
      pop_data  = data_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Update queue written while full.");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Update queue read while empty.");

endmodule
`default_nettype wire

// ----- sv/bads_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box average downscaler back end
// Accumulates block column sums in the column store and divides finished
// block sums by the squared factor with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module bads_back #(
   parameter int MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [DW-1:0]              fsq,
   input  wire logic                       pop_empty,
   output logic                            pop,
   input  wire logic [AW-1:0]              pop_col,
   input  wire logic [SW-1:0]              pop_sum,
   input  wire bads_pkg::bads_flags_type   pop_flags,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [bads_pkg::PIX_W-1:0]      rsp_avg_pixel,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end
);

   localparam int FW_RAW = $clog2(MAX_FACTOR + 1);
   localparam int FW     = (FW_RAW > bads_pkg::ZOOM_W) ? FW_RAW : bads_pkg::ZOOM_W;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int SW     = bads_pkg::PIX_W + 2 * $clog2(MAX_FACTOR);
   localparam int DW     = 2 * FW;
   localparam int PW     = bads_pkg::PIX_W;
   localparam int RW     = DW + PW;
   localparam int TW     = $clog2(PW);
   localparam logic [TW-1:0] LAST_STEP = TW'(PW - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type                state_ff;
   logic [AW-1:0]            col_ff;
   logic [SW-1:0]            sum_ff;
   bads_pkg::bads_flags_type flags_ff;
   logic [SW-1:0]            rd_ff;
   logic [RW-1:0]            rem_ff;
   logic [RW-1:0]            dsh_ff;
   logic [PW-1:0]            quo_ff;
   logic [TW-1:0]            step_ff;
   logic                     out_valid_ff;
   logic [PW-1:0]            out_pix_ff;
   logic                     out_row_ff;
   logic                     out_frame_ff;

   logic [SW-1:0] col_mem [MAX_WIDTH];

   logic [SW-1:0] total;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [PW-1:0] quo_in;
   logic          out_free;
   logic          div_done;
   logic          out_load;

   always_comb begin
      pop      = (state_ff == ST_IDLE) & ~pop_empty;
      total    = flags_ff.first_row ? sum_ff : rd_ff + sum_ff;
      ge       = rem_ff >= dsh_ff;
      rem_in   = ge ? rem_ff - dsh_ff : rem_ff;
      quo_in   = {quo_ff[PW-2:0], ge};
      out_free = ~out_valid_ff | ~rsp_stall;
      div_done = (state_ff == ST_DIV) & (step_ff == LAST_STEP);
      out_load = out_free & (div_done | (state_ff == ST_HOLD));

      rsp_valid     = out_valid_ff;
      rsp_avg_pixel = out_pix_ff;
      rsp_row_end   = out_row_ff;
      rsp_frame_end = out_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
            out_pix_ff   <= div_done ? quo_in : quo_ff;
            out_row_ff   <= flags_ff.row_end;
            out_frame_ff <= flags_ff.frame_end;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  col_ff   <= pop_col;
                  sum_ff   <= pop_sum;
                  flags_ff <= pop_flags;
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               rem_ff  <= RW'(total);
               dsh_ff  <= RW'(fsq) << (PW - 1);
               quo_ff  <= '0;
               step_ff <= '0;
               state_ff <= flags_ff.last_row ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               dsh_ff  <= dsh_ff >> 1;
               quo_ff  <= quo_in;
               step_ff <= step_ff + TW'(1);
               if (div_done) begin
                  state_ff <= out_free ? ST_IDLE : ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= col_mem[pop_col];
      end
      if (state_ff == ST_ACC) begin
         col_mem[col_ff] <= total;
      end
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (rem_in < RW'(fsq)))
      else $error("Block average does not fit in a pixel.");
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (div_done || (state_ff == ST_HOLD)))
      else $error("Output loaded outside the divider finish.");
   a_hold_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && !out_free) |=> (state_ff == ST_HOLD && $stable(quo_ff)))
      else $error("Pending block average lost while output busy.");

endmodule
`default_nettype wire

// ----- test/tb_box_average_image_downscaler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average image downscaler testbench
// Streams grey raster frames of many geometries through the downscaler while
// both sides idle at random, predicts every block average with its own model
// of the raster walk and column store, and checks each output pixel and its
// row and frame end flags in order.
// ----------------------------------------------------------------------------
module tb_box_average_image_downscaler_unit;
   import bads_pkg::*;

   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 750;

   typedef struct packed {
      logic [PIX_W-1:0] avg_pixel;
      logic             row_end;
      logic             frame_end;
   } averaged_pixel_t;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = '0;
   logic [DIM_W-1:0]   csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PIX_W-1:0]   rsp_avg_pixel;
   logic               rsp_row_end;
   logic               rsp_frame_end;

   logic [PIX_W-1:0]   raster_pixels [$];
   averaged_pixel_t    pending_averages [$];
   logic               req_fired = 1'b0;
   logic               csr_fired = 1'b0;
   int                 gap_left = 0;
   int                 burst_left = 0;
   int unsigned        cycle_count = 0;
   int unsigned        error_count = 0;

   logic [ZOOM_W-1:0]  zoom_reg;
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   logic [15:0]        column_sums [0:MAX_WIDTH_DEF-1];
   logic [11:0]        pos_col;
   logic [11:0]        pos_row;
   logic [3:0]         sub_col;
   logic [3:0]         sub_row;
   logic [15:0]        block_acc;

   box_average_image_downscaler_unit uut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_avg_pixel (rsp_avg_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic rewind_raster();
      pos_col   = '0;
      pos_row   = '0;
      sub_col   = '0;
      sub_row   = '0;
      block_acc = '0;
   endtask

   task automatic downscale_pixel(input logic [PIX_W-1:0] pixel);
      int unsigned f, w, h, blocks_x, blocks_y, col, hsum, total;
      averaged_pixel_t result;
      f = clamp_dim(zoom_reg, MAX_FACTOR_DEF);
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      blocks_x = w / f;
      blocks_y = h / f;
      if (pos_col < blocks_x * f && pos_row < blocks_y * f) begin
         col = pos_col / f;
         hsum = (sub_col == 0) ? pixel : block_acc + pixel;
         block_acc = hsum;
         if (sub_col + 1 >= f) begin
            total = (sub_row == 0) ? hsum : column_sums[col] + hsum;
            column_sums[col] = total;
            if (sub_row + 1 >= f) begin
               result.avg_pixel = total / (f * f);
               result.row_end   = (col + 1 >= blocks_x);
               result.frame_end = result.row_end && (pos_row / f + 1 >= blocks_y);
               pending_averages.push_back(result);
            end
         end
      end
      if (pos_col + 1 >= w) begin
         pos_col = '0;
         sub_col = '0;
         if (pos_row + 1 >= h) begin
            pos_row = '0;
            sub_row = '0;
         end else begin
            pos_row = pos_row + 1;
            sub_row = (sub_row + 1 >= f) ? 4'd0 : sub_row + 4'd1;
         end
      end else begin
         pos_col = pos_col + 1;
         sub_col = (sub_col + 1 >= f) ? 4'd0 : sub_col + 4'd1;
      end
   endtask

   always @(posedge clock) begin : monitor
      averaged_pixel_t want;
      req_fired <= !reset && req_valid && !req_stall;
      csr_fired <= !reset && csr_valid && csr_ready;
      if (reset) begin
         zoom_reg   = 5'd1;
         width_reg  = 13'd4096;
         height_reg = 13'd4096;
         rewind_raster();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZOOM:   zoom_reg = csr_data[ZOOM_W-1:0];
               CSR_WIDTH:  width_reg = csr_data;
               CSR_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
            if (csr_index != CSR_UNUSED) rewind_raster();
         end
         if (req_valid && !req_stall) downscale_pixel(req_pixel);
         if (rsp_valid && !rsp_stall) begin
            if (pending_averages.size() == 0) begin
               $error("output pixel %0d arrived with none expected", rsp_avg_pixel);
               error_count++;
            end else begin
               want = pending_averages.pop_front();
               if (rsp_avg_pixel !== want.avg_pixel) begin
                  $error("avg_pixel: expected %0d, actual %0d", want.avg_pixel,
                         rsp_avg_pixel);
                  error_count++;
               end
               if (rsp_row_end !== want.row_end) begin
                  $error("row_end: expected %0d, actual %0d", want.row_end, rsp_row_end);
                  error_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d", want.frame_end,
                         rsp_frame_end);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (raster_pixels.size() != 0) begin
            req_valid <= 1'b1;
            req_pixel <= raster_pixels.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((cycle_count >> 7) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (cycle_count % 5 < 2);
         endcase
      end
   end

   task automatic settle();
      while (raster_pixels.size() != 0 || req_valid || pending_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_pixels(input int count);
      repeat (count) raster_pixels.push_back($urandom_range(0, 255));
   endtask

   initial begin : stimulus
      int unsigned items_sent;
      int unsigned f, w, h, frame_size, n, choice, which, r;
      logic [DIM_W-1:0] zoom_val, width_val, height_val;
      logic [DIM_W-1:0] new_zoom, new_width, new_height;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry passes pixels straight through.
      raster_pixels.push_back(8'd0);
      raster_pixels.push_back(8'd255);
      raster_pixels.push_back(8'h55);
      raster_pixels.push_back(8'hAA);

      // Zero factor, width and height all act as one.
      settle();
      write_register(CSR_ZOOM, 13'd0);
      write_register(CSR_WIDTH, 13'd0);
      write_register(CSR_HEIGHT, 13'd0);
      raster_pixels.push_back(8'd0);
      raster_pixels.push_back(8'd255);
      raster_pixels.push_back(8'd128);

      // A write to the unused index must not restart the frame.
      settle();
      write_register(CSR_ZOOM, 13'd2);
      write_register(CSR_WIDTH, 13'd3);
      write_register(CSR_HEIGHT, 13'd3);
      raster_pixels.push_back(8'd255);
      raster_pixels.push_back(8'd254);
      raster_pixels.push_back(8'd253);
      raster_pixels.push_back(8'd200);
      settle();
      write_register(CSR_UNUSED, 13'h1FFF);
      raster_pixels.push_back(8'd201);
      raster_pixels.push_back(8'd202);
      raster_pixels.push_back(8'd0);
      raster_pixels.push_back(8'd0);
      raster_pixels.push_back(8'd0);

      // Oversized factor and width saturate; the block is taller than the frame.
      settle();
      write_register(CSR_ZOOM, 13'd31);
      write_register(CSR_WIDTH, 13'h1FFF);
      write_register(CSR_HEIGHT, 13'd1);
      raster_pixels.push_back(8'd255);
      raster_pixels.push_back(8'd0);
      raster_pixels.push_back(8'd255);
      raster_pixels.push_back(8'd0);

      // One full block at the largest factor.
      settle();
      zoom_val   = 13'd16;
      width_val  = 13'd17;
      height_val = 13'd16;
      write_register(CSR_ZOOM, zoom_val);
      write_register(CSR_WIDTH, width_val);
      write_register(CSR_HEIGHT, height_val);
      queue_random_pixels(17 * 16);
      items_sent = 17 * 16;

      while (items_sent < RANDOM_PIXELS) begin
         settle();
         r = $urandom_range(0, 19);
         if (r < 16) new_zoom = $urandom_range(1, 4);
         else if (r < 18) new_zoom = $urandom_range(5, 16);
         else if (r == 18) new_zoom = 13'd0;
         else new_zoom = $urandom_range(0, 8191);
         f = clamp_dim(new_zoom[ZOOM_W-1:0], MAX_FACTOR_DEF);

         r = $urandom_range(0, 19);
         if (r < 16) new_width = $urandom_range(f, (f <= 4) ? 3 * f + 2 : f + 3);
         else if (r == 16) new_width = $urandom_range(0, f);
         else if (r == 17) new_width = 13'd4096;
         else if (r == 18) new_width = 13'h1FFF;
         else new_width = $urandom_range(0, 8191);

         r = $urandom_range(0, 19);
         if (r < 16) new_height = $urandom_range(f, (f <= 4) ? 2 * f + 2 : f + 2);
         else if (r == 16) new_height = $urandom_range(0, f);
         else if (r == 17) new_height = 13'd4096;
         else if (r == 18) new_height = 13'h1FFF;
         else new_height = $urandom_range(0, 8191);

         choice = $urandom_range(0, 9);
         which  = $urandom_range(0, 2);
         if (choice < 8 || (choice == 8 && which == 0)) begin
            zoom_val = new_zoom;
            write_register(CSR_ZOOM, zoom_val);
         end
         if (choice < 8 || (choice == 8 && which == 1)) begin
            width_val = new_width;
            write_register(CSR_WIDTH, width_val);
         end
         if (choice < 8 || (choice == 8 && which == 2)) begin
            height_val = new_height;
            write_register(CSR_HEIGHT, height_val);
         end
         if (choice == 9 && which == 0) write_register(CSR_UNUSED, $urandom_range(0, 8191));

         f = clamp_dim(zoom_val[ZOOM_W-1:0], MAX_FACTOR_DEF);
         w = clamp_dim(width_val, MAX_WIDTH_DEF);
         h = clamp_dim(height_val, HEIGHT_LIMIT);
         frame_size = w * h;
         if (frame_size <= 400)
            n = frame_size * $urandom_range(1, (frame_size <= 60) ? 3 : 1)
                + $urandom_range(0, w);
         else
            n = $urandom_range(16, 64);
         queue_random_pixels(n);
         items_sent += n;
      end

      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
